// File: hw/rtl/atrc_pkg.sv
`timescale 1ns / 1ps

package atrc_pkg;

  // Default timing parameters
  localparam int TICKS_PER_UNIT_DEF      = 100;
  localparam int REVERSE_DELAY_TICKS_DEF = 1000;

  // Field widths
  localparam int MODE_W     = 2;
  localparam int UNITS_W    = 10;
  localparam int PHASE_W    = 2;
  localparam int PRESCALE_W = 7;
  localparam int DELAY_W    = 10;
  localparam int DEB_W      = 8;
  localparam int BLINK_W    = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOGIC_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_UNITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_UNITS = 2'd2;

  // Logic modes
  localparam logic [MODE_W-1:0] MODE_STOP    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REVERSE = 2'd1;

  // Run phases
  localparam logic [PHASE_W-1:0] PH_STOP  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_RUN   = 2'd1;
  localparam logic [PHASE_W-1:0] PH_DELAY = 2'd2;

  // Run length limits
  localparam logic [UNITS_W-1:0] RUN_MIN = 10'd40;
  localparam logic [UNITS_W-1:0] RUN_MAX = 10'd900;

  // Debounce reload values
  localparam logic [DEB_W-1:0] DEB_PRESS_FIRST = 8'd100;
  localparam logic [DEB_W-1:0] DEB_PRESS_AGAIN = 8'd255;
  localparam logic [DEB_W-1:0] DEB_RELEASE     = 8'd100;

  // Blinker timing
  localparam logic [BLINK_W-1:0] LAMP_ON_TICKS    = 11'd70;
  localparam logic [BLINK_W-1:0] LAMP_FAST_PERIOD = 11'd140;
  localparam logic [BLINK_W-1:0] LAMP_SLOW_PERIOD = 11'd2000;

  function automatic logic [UNITS_W-1:0] clamp_run(input logic [UNITS_W-1:0] v);
    logic [UNITS_W-1:0] r;
    r = v;
    if (v < RUN_MIN || v > RUN_MAX) begin
      r = RUN_MIN;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/atrc_if.sv
`timescale 1ns / 1ps

interface atrc_in_if;
  logic valid;
  logic ready;
  logic trigger_level;

  modport source (output valid, output trigger_level, input ready);
  modport sink (input valid, input trigger_level, output ready);
endinterface

interface atrc_out_if;
  logic                           valid;
  logic                           ready;
  logic                           relay_open;
  logic                           relay_close;
  logic                           red_lamp;
  logic                           green_lamp;
  logic                           next_is_close;
  logic [atrc_pkg::PHASE_W-1:0]   run_phase;

  modport source (
    output valid, output relay_open, output relay_close, output red_lamp,
    output green_lamp, output next_is_close, output run_phase, input ready
  );
  modport sink (
    input valid, input relay_open, input relay_close, input red_lamp,
    input green_lamp, input next_is_close, input run_phase, output ready
  );
endinterface

// File: hw/rtl/actuator_toggle_run_controller.sv
`timescale 1ns / 1ps
// The result of a tick transaction is registered and valid in the cycle after it is accepted.
// Throughput: one tick per cycle while the result is not stalled; the whole tick update is a single pass of counter
// and compare logic between the state registers and the result register.
// Input is taken while the result register is empty or being drained.
// Reset (rst_n low, synchronous): motor stopped, next run opens, debounce at 100,
// configuration back to mode 0 and 40-unit runs, result register empty.
module actuator_toggle_run_controller #(
  parameter int TICKS_PER_UNIT      = atrc_pkg::TICKS_PER_UNIT_DEF,
  parameter int REVERSE_DELAY_TICKS = atrc_pkg::REVERSE_DELAY_TICKS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  atrc_in_if.sink                           in_ch,
  atrc_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [atrc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [atrc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam logic [atrc_pkg::PRESCALE_W-1:0] TPU =
    atrc_pkg::PRESCALE_W'(TICKS_PER_UNIT);
  localparam logic [atrc_pkg::DELAY_W-1:0] REV_DELAY =
    atrc_pkg::DELAY_W'(REVERSE_DELAY_TICKS);

  // Configuration
  logic [atrc_pkg::MODE_W-1:0]     logic_mode_r;
  logic [atrc_pkg::UNITS_W-1:0]    open_units_r;
  logic [atrc_pkg::UNITS_W-1:0]    close_units_r;

  // Control state
  logic [atrc_pkg::PHASE_W-1:0]    phase_r, phase_nxt;
  logic                            dir_close_r, dir_close_nxt;
  logic [atrc_pkg::UNITS_W-1:0]    run_left_r, run_left_nxt;
  logic [atrc_pkg::PRESCALE_W-1:0] prescale_r, prescale_nxt;
  logic [atrc_pkg::DELAY_W-1:0]    delay_left_r, delay_left_nxt;
  logic [atrc_pkg::DEB_W-1:0]      deb_left_r, deb_left_nxt;
  logic                            await_rel_r, await_rel_nxt;
  logic                            pending_r, pending_nxt;
  logic [atrc_pkg::BLINK_W-1:0]    blink_r, blink_nxt;
  logic                            fast_r, fast_nxt;
  logic                            red_sel_r, red_sel_nxt;
  logic                            green_sel_r, green_sel_nxt;
  logic                            red_pin_r, red_pin_nxt;
  logic                            green_pin_r, green_pin_nxt;

  // Result register
  logic                            out_valid_r;
  logic                            relay_open_r, relay_close_r;
  logic                            red_lamp_r, green_lamp_r, next_close_r;
  logic [atrc_pkg::PHASE_W-1:0]    run_phase_r;

  logic                            in_take;
  logic [atrc_pkg::BLINK_W-1:0]    period;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_comb begin
    phase_nxt      = phase_r;
    dir_close_nxt  = dir_close_r;
    run_left_nxt   = run_left_r;
    prescale_nxt   = prescale_r + 1'b1;
    delay_left_nxt = delay_left_r;
    deb_left_nxt   = deb_left_r;
    await_rel_nxt  = await_rel_r;
    pending_nxt    = pending_r;
    blink_nxt      = blink_r + 1'b1;
    fast_nxt       = fast_r;
    red_sel_nxt    = red_sel_r;
    green_sel_nxt  = green_sel_r;
    red_pin_nxt    = red_pin_r;
    green_pin_nxt  = green_pin_r;

    // unit prescaler and run timer
    if (prescale_nxt >= TPU) begin
      prescale_nxt = '0;
      if (run_left_r != '0) begin
        run_left_nxt = run_left_r - 1'b1;
        if (run_left_nxt == '0) begin
          phase_nxt   = atrc_pkg::PH_STOP;
          pending_nxt = 1'b0;
          fast_nxt    = 1'b0;
        end
      end
    end

    // trigger debounce
    if (await_rel_r) begin
      if (!in_ch.trigger_level) begin
        deb_left_nxt = atrc_pkg::DEB_RELEASE;
      end else begin
        deb_left_nxt = deb_left_r - 1'b1;
        if (deb_left_nxt == '0) begin
          await_rel_nxt = 1'b0;
        end
      end
    end else if (!pending_nxt) begin
      if (in_ch.trigger_level) begin
        deb_left_nxt = atrc_pkg::DEB_PRESS_AGAIN;
      end else begin
        deb_left_nxt = deb_left_r - 1'b1;
        if (deb_left_nxt == '0) begin
          pending_nxt   = 1'b1;
          await_rel_nxt = 1'b1;
        end
      end
    end

    // LED blinker; speed chosen after any expiry this tick
    if (blink_nxt == atrc_pkg::LAMP_ON_TICKS) begin
      red_pin_nxt   = 1'b0;
      green_pin_nxt = 1'b0;
    end
    period = fast_nxt ? atrc_pkg::LAMP_FAST_PERIOD : atrc_pkg::LAMP_SLOW_PERIOD;
    if (blink_nxt >= period) begin
      blink_nxt = '0;
      if (green_sel_r) green_pin_nxt = 1'b1;
      if (red_sel_r) red_pin_nxt = 1'b1;
    end

    // reversal delay countdown
    if (delay_left_r != '0) begin
      delay_left_nxt = delay_left_r - 1'b1;
    end

    // delay ended: start the reverse run, then a pending press sees it running
    if (phase_nxt == atrc_pkg::PH_DELAY && delay_left_nxt == '0) begin
      dir_close_nxt = !dir_close_r;
      red_sel_nxt   = dir_close_r;
      green_sel_nxt = !dir_close_r;
      run_left_nxt  = dir_close_r ? atrc_pkg::clamp_run(close_units_r)
                                  : atrc_pkg::clamp_run(open_units_r);
      fast_nxt      = 1'b1;
      phase_nxt     = atrc_pkg::PH_RUN;
    end

    if (pending_nxt) begin
      if (phase_nxt == atrc_pkg::PH_STOP) begin
        pending_nxt   = 1'b0;
        dir_close_nxt = !dir_close_r;
        red_sel_nxt   = dir_close_r;
        green_sel_nxt = !dir_close_r;
        run_left_nxt  = dir_close_r ? atrc_pkg::clamp_run(close_units_r)
                                    : atrc_pkg::clamp_run(open_units_r);
        fast_nxt      = 1'b1;
        phase_nxt     = atrc_pkg::PH_RUN;
      end else if (phase_nxt == atrc_pkg::PH_RUN) begin
        pending_nxt = 1'b0;
        if (logic_mode_r == atrc_pkg::MODE_STOP) begin
          run_left_nxt = '0;
          fast_nxt     = 1'b0;
          phase_nxt    = atrc_pkg::PH_STOP;
        end else if (logic_mode_r == atrc_pkg::MODE_REVERSE) begin
          run_left_nxt   = '0;
          fast_nxt       = 1'b0;
          delay_left_nxt = REV_DELAY;
          phase_nxt      = atrc_pkg::PH_DELAY;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      logic_mode_r  <= atrc_pkg::MODE_STOP;
      open_units_r  <= atrc_pkg::RUN_MIN;
      close_units_r <= atrc_pkg::RUN_MIN;
    end else if (cfg_we) begin
      case (cfg_index)
        atrc_pkg::CFG_LOGIC_MODE:  logic_mode_r  <= cfg_data[atrc_pkg::MODE_W-1:0];
        atrc_pkg::CFG_OPEN_UNITS:  open_units_r  <= cfg_data;
        atrc_pkg::CFG_CLOSE_UNITS: close_units_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= atrc_pkg::PH_STOP;
      dir_close_r  <= 1'b0;
      run_left_r   <= '0;
      prescale_r   <= '0;
      delay_left_r <= '0;
      deb_left_r   <= atrc_pkg::DEB_PRESS_FIRST;
      await_rel_r  <= 1'b0;
      pending_r    <= 1'b0;
      blink_r      <= '0;
      fast_r       <= 1'b0;
      red_sel_r    <= 1'b1;
      green_sel_r  <= 1'b0;
      red_pin_r    <= 1'b0;
      green_pin_r  <= 1'b0;
    end else if (in_take) begin
      phase_r      <= phase_nxt;
      dir_close_r  <= dir_close_nxt;
      run_left_r   <= run_left_nxt;
      prescale_r   <= prescale_nxt;
      delay_left_r <= delay_left_nxt;
      deb_left_r   <= deb_left_nxt;
      await_rel_r  <= await_rel_nxt;
      pending_r    <= pending_nxt;
      blink_r      <= blink_nxt;
      fast_r       <= fast_nxt;
      red_sel_r    <= red_sel_nxt;
      green_sel_r  <= green_sel_nxt;
      red_pin_r    <= red_pin_nxt;
      green_pin_r  <= green_pin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // load the result with the transaction; hold it while stalled
  always_ff @(posedge clk) begin
    if (in_take) begin
      relay_open_r  <= (phase_nxt == atrc_pkg::PH_RUN) && dir_close_nxt;
      relay_close_r <= (phase_nxt == atrc_pkg::PH_RUN) && !dir_close_nxt;
      red_lamp_r    <= red_pin_nxt;
      green_lamp_r  <= green_pin_nxt;
      next_close_r  <= dir_close_nxt;
      run_phase_r   <= phase_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.relay_open    = relay_open_r;
  assign out_ch.relay_close   = relay_close_r;
  assign out_ch.red_lamp      = red_lamp_r;
  assign out_ch.green_lamp    = green_lamp_r;
  assign out_ch.next_is_close = next_close_r;
  assign out_ch.run_phase     = run_phase_r;

  a_delay_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == atrc_pkg::PH_DELAY |-> delay_left_r != '0)
    else $error("reversal delay phase with zero delay count");

  a_run_has_time: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == atrc_pkg::PH_RUN |-> run_left_r != '0)
    else $error("running with no run time left");

  a_stop_no_time: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == atrc_pkg::PH_STOP |-> run_left_r == '0)
    else $error("stopped with run time left");

  a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> out_ch.valid && out_ch.run_phase == phase_r &&
                out_ch.next_is_close == dir_close_r)
    else $error("result does not match state after transaction");

endmodule

// File: tb/actuator_toggle_run_controller_tb.sv
`timescale 1ns / 1ps

module actuator_toggle_run_controller_tb;

  localparam int TICKS_PER_UNIT      = atrc_pkg::TICKS_PER_UNIT_DEF;
  localparam int REVERSE_DELAY_TICKS = atrc_pkg::REVERSE_DELAY_TICKS_DEF;
  localparam int EPISODES            = 10;
  localparam int STALL_EP            = 2;
  localparam int DRAIN_EP            = 6;
  localparam int BUSY_FIRST_ROW      = 4;
  localparam int BUSY_LAST_ROW       = 5;
  localparam int STALL_CYCLES        = 300;
  localparam int DRAIN_LIMIT         = 2000;
  localparam int TIMEOUT_NS          = 2_000_000;

  localparam logic [atrc_pkg::PRESCALE_W-1:0] TPU_TICKS =
    atrc_pkg::PRESCALE_W'(TICKS_PER_UNIT);
  localparam logic [atrc_pkg::DELAY_W-1:0] REV_TICKS =
    atrc_pkg::DELAY_W'(REVERSE_DELAY_TICKS);

  localparam logic [atrc_pkg::MODE_W-1:0]    MODE_IGNORE = 2'd2;
  localparam logic [atrc_pkg::MODE_W-1:0]    MODE_SPARE  = 2'd3;
  localparam logic [atrc_pkg::CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

  typedef struct packed {
    logic                         relay_open;
    logic                         relay_close;
    logic                         red_lamp;
    logic                         green_lamp;
    logic                         next_is_close;
    logic [atrc_pkg::PHASE_W-1:0] run_phase;
  } tick_result_t;

  typedef enum logic {PLAN_TICKS, PLAN_WRITE} plan_kind_t;

  typedef struct packed {
    plan_kind_t                      kind;
    logic                            lvl;
    logic [12:0]                     count;
    logic [atrc_pkg::CFG_IDX_W-1:0]  idx;
    logic [atrc_pkg::CFG_DATA_W-1:0] val;
    logic                            typed;
    tick_result_t                    want;
  } plan_row_t;

  localparam tick_result_t ALL_OFF    = '0;
  localparam tick_result_t OPEN_FIRST =
    '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1, atrc_pkg::PH_RUN};

  localparam int PLAN_ROWS = 14;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // first low tick after reset changes nothing visible
    '{PLAN_TICKS, 1'b0, 13'd1,   atrc_pkg::CFG_LOGIC_MODE, 10'd0, 1'b1, ALL_OFF},
    // 100 low ticks latch the first press; the opening run starts in that tick
    '{PLAN_TICKS, 1'b0, 13'd99,  atrc_pkg::CFG_LOGIC_MODE, 10'd0, 1'b1, OPEN_FIRST},
    // release right after the latch wraps the counter; 255 high ticks leave it one short
    '{PLAN_TICKS, 1'b1, 13'd255, atrc_pkg::CFG_LOGIC_MODE, 10'd0, 1'b0, ALL_OFF},
    '{PLAN_WRITE, 1'b1, 13'd0, atrc_pkg::CFG_LOGIC_MODE,
      atrc_pkg::CFG_DATA_W'(atrc_pkg::MODE_REVERSE), 1'b0, ALL_OFF},
    // low ticks while running before the release is debounced only reload the release count
    '{PLAN_TICKS, 1'b0, 13'd256, atrc_pkg::CFG_LOGIC_MODE, 10'd0, 1'b0, ALL_OFF},
    '{PLAN_TICKS, 1'b1, 13'd100, atrc_pkg::CFG_LOGIC_MODE, 10'd0, 1'b0, ALL_OFF},
    '{PLAN_WRITE, 1'b1, 13'd0, atrc_pkg::CFG_LOGIC_MODE,
      atrc_pkg::CFG_DATA_W'(MODE_IGNORE), 1'b0, ALL_OFF},
    '{PLAN_TICKS, 1'b0, 13'd40,  atrc_pkg::CFG_LOGIC_MODE, 10'd0, 1'b0, ALL_OFF},
    '{PLAN_WRITE, 1'b1, 13'd0, atrc_pkg::CFG_LOGIC_MODE,
      atrc_pkg::CFG_DATA_W'(MODE_SPARE), 1'b0, ALL_OFF},
    '{PLAN_WRITE, 1'b1, 13'd0, atrc_pkg::CFG_OPEN_UNITS,  10'd1023, 1'b0, ALL_OFF},
    '{PLAN_WRITE, 1'b1, 13'd0, atrc_pkg::CFG_CLOSE_UNITS, 10'd39,   1'b0, ALL_OFF},
    '{PLAN_WRITE, 1'b1, 13'd0, CFG_UNUSED,                10'd1023, 1'b0, ALL_OFF},
    '{PLAN_TICKS, 1'b1, 13'd60,  atrc_pkg::CFG_LOGIC_MODE, 10'd0, 1'b0, ALL_OFF},
    '{PLAN_WRITE, 1'b1, 13'd0, atrc_pkg::CFG_LOGIC_MODE,
      atrc_pkg::CFG_DATA_W'(atrc_pkg::MODE_STOP), 1'b0, ALL_OFF}
  };

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [atrc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [atrc_pkg::CFG_DATA_W-1:0] cfg_data;

  // typed expectation rides along with the offered tick
  logic                  offer_typed;
  tick_result_t          offer_want;

  bit send_idle_on = 1'b1;
  bit recv_idle_on = 1'b1;
  bit stall_req    = 1'b0;
  int fail_count   = 0;

  tick_result_t expected_status [$];

  // predicted block state and registers
  logic [atrc_pkg::MODE_W-1:0]     mode_reg;
  logic [atrc_pkg::UNITS_W-1:0]    open_units_reg;
  logic [atrc_pkg::UNITS_W-1:0]    close_units_reg;
  logic [atrc_pkg::PHASE_W-1:0]    mtr_phase;
  logic                            mtr_next_close;
  logic [atrc_pkg::UNITS_W-1:0]    units_left;
  logic [atrc_pkg::PRESCALE_W-1:0] unit_div;
  logic [atrc_pkg::DELAY_W-1:0]    rev_wait;
  logic [atrc_pkg::DEB_W-1:0]      deb_count;
  logic                            deb_release;
  logic                            press_latched;
  logic [atrc_pkg::BLINK_W-1:0]    blink_ticks;
  logic                            blink_fast;
  logic                            red_sel;
  logic                            green_sel;
  logic                            red_on;
  logic                            green_on;

  atrc_in_if  tick_ch ();
  atrc_out_if status_ch ();

  actuator_toggle_run_controller #(
    .TICKS_PER_UNIT      (TICKS_PER_UNIT),
    .REVERSE_DELAY_TICKS (REVERSE_DELAY_TICKS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (tick_ch),
    .out_ch    (status_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic void clear_model();
    mode_reg        = atrc_pkg::MODE_STOP;
    open_units_reg  = atrc_pkg::RUN_MIN;
    close_units_reg = atrc_pkg::RUN_MIN;
    mtr_phase       = atrc_pkg::PH_STOP;
    mtr_next_close  = 1'b0;
    units_left      = '0;
    unit_div        = '0;
    rev_wait        = '0;
    deb_count       = atrc_pkg::DEB_PRESS_FIRST;
    deb_release     = 1'b0;
    press_latched   = 1'b0;
    blink_ticks     = '0;
    blink_fast      = 1'b0;
    red_sel         = 1'b1;
    green_sel       = 1'b0;
    red_on          = 1'b0;
    green_on        = 1'b0;
  endfunction

  function automatic logic [atrc_pkg::UNITS_W-1:0] legal_units(
    input logic [atrc_pkg::UNITS_W-1:0] u);
    return (u < atrc_pkg::RUN_MIN || u > atrc_pkg::RUN_MAX) ? atrc_pkg::RUN_MIN : u;
  endfunction

  function automatic void launch_run();
    if (mtr_next_close) begin
      mtr_next_close = 1'b0;
      red_sel        = 1'b1;
      green_sel      = 1'b0;
      units_left     = legal_units(close_units_reg);
    end else begin
      mtr_next_close = 1'b1;
      red_sel        = 1'b0;
      green_sel      = 1'b1;
      units_left     = legal_units(open_units_reg);
    end
    blink_fast = 1'b1;
    mtr_phase  = atrc_pkg::PH_RUN;
  endfunction

  function automatic tick_result_t advance_tick(input logic pin_high);
    tick_result_t                 r;
    logic [atrc_pkg::BLINK_W-1:0] off_time;
    unit_div = unit_div + 1'b1;
    if (unit_div >= TPU_TICKS) begin
      unit_div = '0;
      if (units_left != '0) begin
        units_left = units_left - 1'b1;
        if (units_left == '0) begin
          mtr_phase     = atrc_pkg::PH_STOP;
          press_latched = 1'b0;
          blink_fast    = 1'b0;
        end
      end
    end

    if (deb_release) begin
      if (!pin_high) begin
        deb_count = atrc_pkg::DEB_RELEASE;
      end else begin
        deb_count = deb_count - 1'b1;
        if (deb_count == '0) deb_release = 1'b0;
      end
    end else if (!press_latched) begin
      if (pin_high) begin
        deb_count = atrc_pkg::DEB_PRESS_AGAIN;
      end else begin
        deb_count = deb_count - 1'b1;
        if (deb_count == '0) begin
          press_latched = 1'b1;
          deb_release   = 1'b1;
        end
      end
    end

    blink_ticks = blink_ticks + 1'b1;
    if (blink_ticks == atrc_pkg::LAMP_ON_TICKS) begin
      red_on   = 1'b0;
      green_on = 1'b0;
    end
    off_time = blink_fast ? atrc_pkg::LAMP_FAST_PERIOD : atrc_pkg::LAMP_SLOW_PERIOD;
    if (blink_ticks >= off_time) begin
      blink_ticks = '0;
      if (green_sel) green_on = 1'b1;
      if (red_sel) red_on = 1'b1;
    end

    if (rev_wait != '0) rev_wait = rev_wait - 1'b1;

    if (mtr_phase == atrc_pkg::PH_DELAY && rev_wait == '0) launch_run();
    if (press_latched) begin
      if (mtr_phase == atrc_pkg::PH_STOP) begin
        press_latched = 1'b0;
        launch_run();
      end else if (mtr_phase == atrc_pkg::PH_RUN) begin
        press_latched = 1'b0;
        if (mode_reg == atrc_pkg::MODE_STOP) begin
          units_left = '0;
          blink_fast = 1'b0;
          mtr_phase  = atrc_pkg::PH_STOP;
        end else if (mode_reg == atrc_pkg::MODE_REVERSE) begin
          units_left = '0;
          blink_fast = 1'b0;
          rev_wait   = REV_TICKS;
          mtr_phase  = atrc_pkg::PH_DELAY;
        end
      end
    end

    r.relay_open    = (mtr_phase == atrc_pkg::PH_RUN) && mtr_next_close;
    r.relay_close   = (mtr_phase == atrc_pkg::PH_RUN) && !mtr_next_close;
    r.red_lamp      = red_on;
    r.green_lamp    = green_on;
    r.next_is_close = mtr_next_close;
    r.run_phase     = mtr_phase;
    return r;
  endfunction

  function automatic void check_field(input string field, input logic [1:0] exp_v,
                                      input logic [1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", field, exp_v, act_v);
      fail_count++;
    end
  endfunction

  function automatic logic [atrc_pkg::UNITS_W-1:0] pick_units();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return atrc_pkg::UNITS_W'($urandom_range(55, 40));
    if (r < 65) return atrc_pkg::RUN_MAX;
    if (r < 75) return atrc_pkg::RUN_MIN;
    if (r < 85) return atrc_pkg::UNITS_W'($urandom_range(39, 0));
    if (r < 95) return atrc_pkg::UNITS_W'($urandom_range(1023, 901));
    return ($urandom_range(1) != 0) ? '0 : '1;
  endfunction

  always @(posedge clk) begin : status_check
    tick_result_t seen;
    tick_result_t want_now;
    if (!rst_n) begin
      clear_model();
      expected_status.delete();
    end else begin
      if (status_ch.valid && status_ch.ready) begin
        seen = '{status_ch.relay_open, status_ch.relay_close, status_ch.red_lamp,
                 status_ch.green_lamp, status_ch.next_is_close, status_ch.run_phase};
        if (expected_status.size() == 0) begin
          $error("result transaction with no tick outstanding");
          fail_count++;
        end else begin
          want_now = expected_status.pop_front();
          check_field("relay_open", 2'(want_now.relay_open), 2'(seen.relay_open));
          check_field("relay_close", 2'(want_now.relay_close), 2'(seen.relay_close));
          check_field("red_lamp", 2'(want_now.red_lamp), 2'(seen.red_lamp));
          check_field("green_lamp", 2'(want_now.green_lamp), 2'(seen.green_lamp));
          check_field("next_is_close", 2'(want_now.next_is_close),
                      2'(seen.next_is_close));
          check_field("run_phase", want_now.run_phase, seen.run_phase);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          atrc_pkg::CFG_LOGIC_MODE:  mode_reg = cfg_data[atrc_pkg::MODE_W-1:0];
          atrc_pkg::CFG_OPEN_UNITS:  open_units_reg = cfg_data[atrc_pkg::UNITS_W-1:0];
          atrc_pkg::CFG_CLOSE_UNITS: close_units_reg = cfg_data[atrc_pkg::UNITS_W-1:0];
          default: ;
        endcase
      end
      if (tick_ch.valid && tick_ch.ready) begin
        want_now = advance_tick(tick_ch.trigger_level);
        if (offer_typed) want_now = offer_want;
        expected_status.push_back(want_now);
      end
    end
  end

  initial begin : result_sink
    int held;
    status_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (stall_req) begin
        // hold off long enough for the block to back up into its input
        status_ch.ready <= 1'b0;
        for (held = 0; held < STALL_CYCLES; held++) @(posedge clk);
        stall_req = 1'b0;
      end else begin
        status_ch.ready <= !(recv_idle_on && $urandom_range(99) < 35);
        @(posedge clk);
      end
    end
  end

  task automatic send_tick(input logic lvl, input logic typed, input tick_result_t want);
    while (send_idle_on && $urandom_range(99) < 35) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tick_ch.valid         <= 1'b1;
    tick_ch.trigger_level <= lvl;
    offer_typed           <= typed;
    offer_want            <= want;
    do @(posedge clk); while (!tick_ch.ready);
  endtask

  task automatic hold_level(input logic lvl, input int unsigned n);
    repeat (n) send_tick(lvl, 1'b0, ALL_OFF);
  endtask

  task automatic settle();
    int n;
    tick_ch.valid <= 1'b0;
    @(posedge clk);
    for (n = 0; n < DRAIN_LIMIT && expected_status.size() != 0; n++) @(posedge clk);
    if (expected_status.size() != 0) begin
      $error("%0d results never arrived", expected_status.size());
      fail_count++;
      expected_status.delete();
    end
  endtask

  task automatic write_reg(input logic [atrc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [atrc_pkg::CFG_DATA_W-1:0] val);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    int r;
    int k;
    int ep;
    int unsigned shape;
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = atrc_pkg::CFG_LOGIC_MODE;
    cfg_data              = '0;
    tick_ch.valid         = 1'b0;
    tick_ch.trigger_level = 1'b1;
    offer_typed           = 1'b0;
    offer_want            = ALL_OFF;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (r = 0; r < PLAN_ROWS; r++) begin
      // run the busy rows (low then high ticks while running) with no idling on either side
      send_idle_on = (r < BUSY_FIRST_ROW || r > BUSY_LAST_ROW);
      recv_idle_on = send_idle_on;
      if (PLAN[r].kind == PLAN_WRITE) begin
        write_reg(PLAN[r].idx, PLAN[r].val);
      end else begin
        for (k = 1; k <= PLAN[r].count; k++) begin
          send_tick(PLAN[r].lvl, PLAN[r].typed && k == PLAN[r].count, PLAN[r].want);
        end
      end
    end

    for (ep = 0; ep < EPISODES; ep++) begin
      if (ep == DRAIN_EP) settle();

      if ($urandom_range(99) < 30) begin
        case ($urandom_range(3))
          0: write_reg(atrc_pkg::CFG_LOGIC_MODE, atrc_pkg::CFG_DATA_W'($urandom));
          1: write_reg(atrc_pkg::CFG_OPEN_UNITS, pick_units());
          2: write_reg(atrc_pkg::CFG_CLOSE_UNITS, pick_units());
          default: write_reg(CFG_UNUSED, atrc_pkg::CFG_DATA_W'($urandom));
        endcase
      end

      if (ep == STALL_EP) stall_req = 1'b1;

      shape = $urandom_range(99);
      if (shape < 40) begin
        hold_level(1'b0, $urandom_range(16, 4));
      end else if (shape < 70) begin
        hold_level(1'b1, $urandom_range(16, 4));
      end else begin
        repeat ($urandom_range(16, 4)) send_tick(1'($urandom_range(1)), 1'b0, ALL_OFF);
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

endmodule
